[src/sfr_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the serial frame receiver.
// Depends on nothing; the parser, output buffer and top level import it.
package sfr_pkg;

  localparam int unsigned HEADER_BYTES = 13;

  localparam logic [7:0]  MARK0 = 8'h55;
  localparam logic [7:0]  MARK1 = 8'h61;
  localparam logic [7:0]  MARK2 = 8'h72;
  localparam logic [7:0]  MARK3 = 8'h54;

  localparam logic [3:0]  HC_MARKER_DONE = 4'd4;
  localparam logic [3:0]  HC_CRC_START   = 4'd8;
  localparam logic [3:0]  HC_LEN_POS     = 4'd12;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_BODY   = 3'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [31:0] command;
    logic [7:0]  byte_index;
    logic        frame_last;
    logic        empty_frame;
    logic        crc_ok;
  } sfr_result_t;

  function automatic logic [7:0] marker_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = MARK0;
      2'd1:    m = MARK1;
      2'd2:    m = MARK2;
      default: m = MARK3;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/sfr_channels.sv]
// Valid/ready channel interfaces for the serial frame receiver.
// Depends on nothing.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_byte;
  logic [31:0] command;
  logic [7:0]  byte_index;
  logic        frame_last;
  logic        empty_frame;
  logic        crc_ok;

  modport source (output valid, output body_byte, output command, output byte_index,
                  output frame_last, output empty_frame, output crc_ok, input ready);
  modport sink   (input valid, input body_byte, input command, input byte_index,
                  input frame_last, input empty_frame, input crc_ok, output ready);
endinterface

[src/sfr_parser.sv]
// Frame parser: marker hunt, header assembly, body CRC, one result per body byte (one result for an empty frame).
// Depends on sfr_pkg.
module sfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output sfr_pkg::sfr_result_t res
);
  import sfr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [31:0] cmd_r, cmd_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic [3:0]  hunt_hc;
  logic [31:0] crc_upd;
  logic [8:0]  idx_inc;
  logic        body_last;

  assign crc_upd   = crc_byte(crc_r, rx_byte);
  assign idx_inc   = {1'b0, cnt_r} + 9'd1;
  assign body_last = (idx_inc >= {1'b0, len_r});
  assign hunt_hc   = (hc_r > 4'd3) ? 4'd0 : hc_r;

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    cmd_nxt   = cmd_r;
    exp_nxt   = exp_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    res_valid = 1'b0;
    res       = '0;
    case (phase_r)
      PH_HEADER: begin
        if (hc_r >= HC_MARKER_DONE && hc_r < HC_CRC_START) begin
          cmd_nxt[8*hc_r[1:0] +: 8] = cmd_r[8*hc_r[1:0] +: 8] | rx_byte;
          hc_nxt = hc_r + 4'd1;
        end else if (hc_r >= HC_CRC_START && hc_r < HC_LEN_POS) begin
          exp_nxt[8*hc_r[1:0] +: 8] = exp_r[8*hc_r[1:0] +: 8] | rx_byte;
          hc_nxt = hc_r + 4'd1;
        end else begin
          len_nxt = rx_byte;
          cnt_nxt = 8'd0;
          crc_nxt = CRC_INIT;
          hc_nxt  = 4'd0;
          if (rx_byte == 8'd0) begin
            phase_nxt       = PH_HUNT;
            res_valid       = 1'b1;
            res.command     = cmd_r;
            res.frame_last  = 1'b1;
            res.empty_frame = 1'b1;
            res.crc_ok      = (exp_r == 32'd0);
          end else begin
            phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_nxt        = crc_upd;
        cnt_nxt        = idx_inc[7:0];
        res_valid      = 1'b1;
        res.body_byte  = rx_byte;
        res.command    = cmd_r;
        res.byte_index = cnt_r;
        res.frame_last = body_last;
        res.crc_ok     = body_last && ((crc_upd ^ CRC_INIT) == exp_r);
        if (body_last) begin
          phase_nxt = PH_HUNT;
          hc_nxt    = 4'd0;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == marker_byte(hunt_hc[1:0])) begin
          hc_nxt = hunt_hc + 4'd1;
        end else begin
          hc_nxt = (rx_byte == MARK0) ? 4'd1 : 4'd0;
        end
        if (hc_nxt == HC_MARKER_DONE) begin
          phase_nxt = PH_HEADER;
          cmd_nxt   = 32'd0;
          exp_nxt   = 32'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      hc_r    <= 4'd0;
      cmd_r   <= 32'd0;
      exp_r   <= 32'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      crc_r   <= CRC_INIT;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      cmd_r   <= cmd_nxt;
      exp_r   <= exp_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

[src/sfr_out_buf.sv]
// Result register with a skid stage so input transfers continue while a result waits.
// Depends on sfr_pkg.
module sfr_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfr_pkg::sfr_result_t push_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output sfr_pkg::sfr_result_t out_data
);
  import sfr_pkg::*;

  logic        main_v_r, skid_v_r;
  sfr_result_t main_r, skid_r;

  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_v_r <= 1'b1;
        skid_v_r <= push;
      end else begin
        main_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_r <= skid_r;
        skid_r <= push_data;
      end else begin
        main_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

[src/serial_frame_receiver.sv]
// Serial frame receiver top level: marker hunt, header parse, CRC-32 checked body output.
// Depends on sfr_pkg, sfr_channels, sfr_parser and sfr_out_buf.
//
//   channel   dir  payload
//   in_ch     in   rx_byte
//   out_ch    out  body_byte, command, byte_index, frame_last, empty_frame, crc_ok
//
// One byte transfers per cycle while the output buffer has space; each result is registered there before out_ch.
// The byte-wide CRC update and the header/marker logic are combinational.
// Synchronous active-low reset returns the parser to marker hunt.
// A two-entry output buffer keeps in_ch ready while one result stalls on out_ch.
module serial_frame_receiver (
  input  logic            clk,
  input  logic            rst_n,
  sfr_in_if.sink          in_ch,
  sfr_out_if.source       out_ch
);
  import sfr_pkg::*;

  logic        in_fire;
  logic        res_valid;
  logic        space;
  sfr_result_t res;
  sfr_result_t out_data;

  assign in_ch.ready = space;
  assign in_fire     = in_ch.valid && space;

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_ch.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.body_byte   = out_data.body_byte;
  assign out_ch.command     = out_data.command;
  assign out_ch.byte_index  = out_data.byte_index;
  assign out_ch.frame_last  = out_data.frame_last;
  assign out_ch.empty_frame = out_data.empty_frame;
  assign out_ch.crc_ok      = out_data.crc_ok;

endmodule
